FILE: rtl/core/wsm_pkg.sv
// Shared types and constants of the wildcard string matcher.
package wsm_pkg;

  localparam int SYM_W   = 5;
  localparam int START_W = 20;
  localparam int TOTAL_W = 21;

  localparam logic [SYM_W-1:0]   SYM_WILD  = 5'd0;
  localparam logic [TOTAL_W-1:0] COUNT_MAX = 21'h1FFFFF;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEXT   = 2'd2,
    FUNC_END    = 2'd3
  } func_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic restart;
    logic step;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/wildcard_string_matcher_core.sv
// Top level of the wildcard string matcher: control, counters, cell chain and result register.
//
// Usage: items enter on the in_ channel (in_func, in_symbol) and results leave on the
// out_ channel (out_match_start, out_match_total, out_is_final), both with valid/stall.
// Clear empties the pattern; append, if the chain is not full, pushes a pattern symbol (0 is
// a wildcard) and restarts the text; a text item steps every cell at once if fewer than MAX_TEXT
// were counted; end of text gives one final result with the match count and restarts the text.
// The pattern lives in a chain of MAX_PATTERN cells. An append shifts the symbols one
// cell along, so the newest symbol sits in cell 0 and the full match shows there.
// Throughput is one item per cycle while in_stall is low; a result appears on the out_ ports
// in the cycle after its item is accepted. The cell update is a single compare and AND per cell.
// When the receiver stalls with a result waiting, in_stall is raised until the result
// is taken. Reset empties the pattern and clears the counters and partial bits; the block
// takes items as soon as reset is released.
module wildcard_string_matcher_core #(
  parameter int MAX_PATTERN = 1024,
  parameter int MAX_TEXT    = 1048576
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_func,
  input  logic [wsm_pkg::SYM_W-1:0]    in_symbol,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [wsm_pkg::START_W-1:0]  out_match_start,
  output logic [wsm_pkg::TOTAL_W-1:0]  out_match_total,
  output logic                         out_is_final
);

  localparam int PLW = $clog2(MAX_PATTERN + 1);
  localparam int TPW = $clog2(MAX_TEXT + 1);

  logic [PLW-1:0]              plen_r, plen_nxt;
  logic [TPW-1:0]              tpos_r, tpos_nxt;
  logic [wsm_pkg::TOTAL_W-1:0] mcount_r, mcount_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [wsm_pkg::START_W-1:0] out_start_r, out_start_nxt;
  logic [wsm_pkg::TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic                        out_final_r, out_final_nxt;

  logic                        acc;
  logic                        full;
  logic                        room;
  logic                        hit;
  logic [31:0]                 start_full;
  wsm_pkg::func_t              func;
  wsm_pkg::cell_ctrl_t         ctrl;

  logic [wsm_pkg::SYM_W-1:0]   sym_w  [MAX_PATTERN];
  logic                        vld_w  [MAX_PATTERN];
  logic                        part_w [MAX_PATTERN];
  logic                        hit_w  [MAX_PATTERN];

  assign in_stall = out_valid_r & out_stall;
  assign acc      = in_valid & ~in_stall;
  assign func     = wsm_pkg::func_t'(in_func);
  assign full     = vld_w[MAX_PATTERN-1];
  assign room     = (tpos_r < TPW'(MAX_TEXT));
  assign hit      = hit_w[0];

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [wsm_pkg::SYM_W-1:0] sym_in;
    logic                      vld_in;
    logic                      prev_in;

    if (i == 0) begin : g_head
      assign sym_in = in_symbol;
      assign vld_in = 1'b1;
    end else begin : g_body
      assign sym_in = sym_w[i-1];
      assign vld_in = vld_w[i-1];
    end

    if (i == MAX_PATTERN - 1) begin : g_tail
      assign prev_in = 1'b1;
    end else begin : g_link
      assign prev_in = part_w[i+1];
    end

    wsm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .text_sym (in_symbol),
      .sym_in   (sym_in),
      .vld_in   (vld_in),
      .prev_in  (prev_in),
      .sym_out  (sym_w[i]),
      .vld_out  (vld_w[i]),
      .part_out (part_w[i]),
      .hit_out  (hit_w[i])
    );
  end

  assign start_full = 32'(tpos_r) + 32'd1 - 32'(plen_r);

  always_comb begin
    ctrl          = '0;
    plen_nxt      = plen_r;
    tpos_nxt      = tpos_r;
    mcount_nxt    = mcount_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_start_nxt = out_start_r;
    out_total_nxt = out_total_r;
    out_final_nxt = out_final_r;
    if (acc) begin
      unique case (func)
        wsm_pkg::FUNC_CLEAR: begin
          ctrl.clear = 1'b1;
          plen_nxt   = '0;
          tpos_nxt   = '0;
          mcount_nxt = '0;
        end
        wsm_pkg::FUNC_APPEND: begin
          if (!full) begin
            ctrl.shift = 1'b1;
            plen_nxt   = plen_r + PLW'(1);
            tpos_nxt   = '0;
            mcount_nxt = '0;
          end
        end
        wsm_pkg::FUNC_TEXT: begin
          if (room) begin
            ctrl.step = 1'b1;
            tpos_nxt  = tpos_r + TPW'(1);
            if (hit) begin
              if (mcount_r != wsm_pkg::COUNT_MAX) begin
                mcount_nxt = mcount_r + wsm_pkg::TOTAL_W'(1);
              end
              out_valid_nxt = 1'b1;
              out_start_nxt = start_full[wsm_pkg::START_W-1:0];
              out_total_nxt = '0;
              out_final_nxt = 1'b0;
            end
          end
        end
        wsm_pkg::FUNC_END: begin
          ctrl.restart  = 1'b1;
          tpos_nxt      = '0;
          mcount_nxt    = '0;
          out_valid_nxt = 1'b1;
          out_start_nxt = '0;
          out_total_nxt = mcount_r;
          out_final_nxt = 1'b1;
        end
        default: begin
          ctrl = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r      <= '0;
      tpos_r      <= '0;
      mcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      plen_r      <= plen_nxt;
      tpos_r      <= tpos_nxt;
      mcount_r    <= mcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_start_r <= out_start_nxt;
    out_total_r <= out_total_nxt;
    out_final_r <= out_final_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_match_start = out_start_r;
  assign out_match_total = out_total_r;
  assign out_is_final    = out_final_r;

  // A full match can only come from a non-empty pattern.
  a_hit_needs_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> plen_r != '0)
    else $error("match reported with an empty pattern");

  // The cell chain and the length counter agree on whether the pattern is full.
  a_full_matches_len: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> plen_r == PLW'(MAX_PATTERN))
    else $error("pattern chain full but length counter disagrees");

  // End of text leaves the text counters cleared.
  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && func == wsm_pkg::FUNC_END) |=> (tpos_r == '0 && mcount_r == '0))
    else $error("text state not cleared after end of text");

  // Input is held back only while a result waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no result pending");

endmodule

FILE: rtl/core/wsm_cell.sv
// One cell of the matcher chain: a pattern symbol, its valid flag and its partial match bit.
module wsm_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wsm_pkg::cell_ctrl_t        ctrl,
  input  logic [wsm_pkg::SYM_W-1:0]  text_sym,
  input  logic [wsm_pkg::SYM_W-1:0]  sym_in,
  input  logic                       vld_in,
  input  logic                       prev_in,
  output logic [wsm_pkg::SYM_W-1:0]  sym_out,
  output logic                       vld_out,
  output logic                       part_out,
  output logic                       hit_out
);

  logic [wsm_pkg::SYM_W-1:0] sym_r;
  logic                      vld_r;
  logic                      part_r;
  logic                      part_nxt;

  // The cell nearer the newest symbol holds the longer prefix, so the chain
  // carries prefix bits towards cell 0, where the full match appears.
  assign part_nxt = vld_r && prev_in &&
                    ((sym_r == wsm_pkg::SYM_WILD) || (sym_r == text_sym));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      part_r <= 1'b0;
    end else begin
      priority if (ctrl.clear) begin
        vld_r  <= 1'b0;
        part_r <= 1'b0;
      end else if (ctrl.shift) begin
        vld_r  <= vld_in;
        part_r <= 1'b0;
      end else if (ctrl.restart) begin
        part_r <= 1'b0;
      end else if (ctrl.step) begin
        part_r <= part_nxt;
      end else begin
        part_r <= part_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      sym_r <= sym_in;
    end
  end

  // An empty cell acts as the start of the chain: its prefix is always met.
  assign sym_out  = sym_r;
  assign vld_out  = vld_r;
  assign part_out = part_r | ~vld_r;
  assign hit_out  = part_nxt;

endmodule
